>>> design/bmp_pkg.sv
// Package for the blocked matrix pack address generator.
// Holds field widths, command and register codes, and the word types between stages.
// No dependencies.
`default_nettype none

package bmp_pkg;

   localparam int ADDR_W    = 32;
   localparam int DIM_W     = 16;
   localparam int STRIDE_W  = 24;
   localparam int CSR_IDX_W = 3;
   localparam int MAT_W     = 17;
   localparam int EXT_W     = MAT_W + 1;
   localparam int IDX_W     = 16;
   localparam int TIDX_W    = 6;
   localparam int DIM_MAX   = (1 << DIM_W) - 1;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_NEXT  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS             = 3'd0,
      CSR_COLS             = 3'd1,
      CSR_SRC_ROW_STRIDE   = 3'd2,
      CSR_SRC_COL_STRIDE   = 3'd3,
      CSR_TILE_ROW_STRIDE  = 3'd4,
      CSR_TILE_COL_STRIDE  = 3'd5,
      CSR_BLOCK_ROW_STRIDE = 3'd6,
      CSR_BLOCK_COL_STRIDE = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]    rows;
      logic [DIM_W-1:0]    cols;
      logic [STRIDE_W-1:0] src_row_stride;
      logic [STRIDE_W-1:0] src_col_stride;
      logic [STRIDE_W-1:0] tile_row_stride;
      logic [STRIDE_W-1:0] tile_col_stride;
      logic [STRIDE_W-1:0] block_row_stride;
      logic [STRIDE_W-1:0] block_col_stride;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] src_base;
      logic [ADDR_W-1:0] dst_base;
      logic [MAT_W-1:0]  mrow;
      logic [MAT_W-1:0]  mcol;
      logic [IDX_W-1:0]  row_block;
      logic [IDX_W-1:0]  col_block;
      logic [TIDX_W-1:0] row_in_tile;
      logic [TIDX_W-1:0] col_in_tile;
      logic              pad;
      logic              last;
   } elem_type;

   typedef struct packed {
      logic [ADDR_W-1:0] src_base;
      logic [ADDR_W-1:0] dst_base;
      logic [ADDR_W-1:0] src_row_term;
      logic [ADDR_W-1:0] src_col_term;
      logic [ADDR_W-1:0] block_row_term;
      logic [ADDR_W-1:0] block_col_term;
      logic [ADDR_W-1:0] tile_row_term;
      logic [ADDR_W-1:0] tile_col_term;
      logic              pad;
      logic              last;
   } prod_type;

endpackage

`default_nettype wire

>>> design/bmp_ctr.sv
// Element counter stage: walks row block, column block, row and column in tile.
// Latches the base addresses on start words and registers one element word per move.
// Depends on bmp_pkg.
`default_nettype none

module bmp_ctr
   import bmp_pkg::*;
#(
   parameter int TILE_ROWS = 8,
   parameter int TILE_COLS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [DIM_W-1:0]  rows,
   input  logic [DIM_W-1:0]  cols,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic [ADDR_W-1:0] req_src_base,
   input  logic [ADDR_W-1:0] req_dst_base,
   input  logic              next_ready,
   output logic              elem_valid,
   output elem_type          elem
);

   localparam int RT_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
   localparam int CT_W = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
   localparam int NRB  = (DIM_MAX + TILE_ROWS - 1) / TILE_ROWS;
   localparam int NCB  = (DIM_MAX + TILE_COLS - 1) / TILE_COLS;
   localparam int RB_W = (NRB > 1) ? $clog2(NRB) : 1;
   localparam int CB_W = (NCB > 1) ? $clog2(NCB) : 1;

   logic [RB_W-1:0]   rb_ff, rb_in;
   logic [CB_W-1:0]   cb_ff, cb_in;
   logic [RT_W-1:0]   rit_ff, rit_in;
   logic [CT_W-1:0]   cit_ff, cit_in;
   logic [ADDR_W-1:0] src_base_ff, src_base_in;
   logic [ADDR_W-1:0] dst_base_ff, dst_base_in;
   logic              elem_valid_ff, elem_valid_in;
   elem_type          elem_ff, elem_in;

   logic [MAT_W-1:0]  mrow_base, mcol_base, mrow, mcol;
   logic              end_c, end_r, end_cb, end_rb;
   logic              take, take_next;

   assign req_ready = !elem_valid_ff || next_ready;
   assign take      = req_valid && req_ready;
   assign take_next = take && (cmd_type'(req_cmd) == CMD_NEXT);

   assign mrow_base = MAT_W'(rb_ff) * MAT_W'(TILE_ROWS);
   assign mcol_base = MAT_W'(cb_ff) * MAT_W'(TILE_COLS);
   assign mrow      = mrow_base + MAT_W'(rit_ff);
   assign mcol      = mcol_base + MAT_W'(cit_ff);

   assign end_c  = cit_ff >= CT_W'(TILE_COLS - 1);
   assign end_r  = rit_ff >= RT_W'(TILE_ROWS - 1);
   assign end_cb = (cols == '0) ||
                   ((EXT_W'(mcol_base) + EXT_W'(TILE_COLS)) >= EXT_W'(cols));
   assign end_rb = (rows == '0) ||
                   ((EXT_W'(mrow_base) + EXT_W'(TILE_ROWS)) >= EXT_W'(rows));

   always_comb begin
      rb_in       = rb_ff;
      cb_in       = cb_ff;
      rit_in      = rit_ff;
      cit_in      = cit_ff;
      src_base_in = src_base_ff;
      dst_base_in = dst_base_ff;
      if (take && !take_next) begin
         rb_in       = '0;
         cb_in       = '0;
         rit_in      = '0;
         cit_in      = '0;
         src_base_in = req_src_base;
         dst_base_in = req_dst_base;
      end else if (take_next) begin
         if (!end_c) begin
            cit_in = cit_ff + 1'b1;
         end else begin
            cit_in = '0;
            if (!end_r) begin
               rit_in = rit_ff + 1'b1;
            end else begin
               rit_in = '0;
               if (!end_cb) begin
                  cb_in = cb_ff + 1'b1;
               end else begin
                  cb_in = '0;
                  if (!end_rb) begin
                     rb_in = rb_ff + 1'b1;
                  end else begin
                     rb_in = '0;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      elem_in.src_base    = src_base_ff;
      elem_in.dst_base    = dst_base_ff;
      elem_in.mrow        = mrow;
      elem_in.mcol        = mcol;
      elem_in.row_block   = IDX_W'(rb_ff);
      elem_in.col_block   = IDX_W'(cb_ff);
      elem_in.row_in_tile = TIDX_W'(rit_ff);
      elem_in.col_in_tile = TIDX_W'(cit_ff);
      elem_in.pad         = !((mrow < MAT_W'(rows)) && (mcol < MAT_W'(cols)));
      elem_in.last        = end_c && end_r && end_cb && end_rb;
   end

   always_comb begin
      elem_valid_in = elem_valid_ff;
      if (req_ready) begin
         elem_valid_in = take_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rb_ff         <= '0;
         cb_ff         <= '0;
         rit_ff        <= '0;
         cit_ff        <= '0;
         src_base_ff   <= '0;
         dst_base_ff   <= '0;
         elem_valid_ff <= 1'b0;
      end else begin
         rb_ff         <= rb_in;
         cb_ff         <= cb_in;
         rit_ff        <= rit_in;
         cit_ff        <= cit_in;
         src_base_ff   <= src_base_in;
         dst_base_ff   <= dst_base_in;
         elem_valid_ff <= elem_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_next) begin
         elem_ff <= elem_in;
      end
   end

   assign elem_valid = elem_valid_ff;
   assign elem       = elem_ff;

endmodule

`default_nettype wire

>>> design/bmp_mul.sv
// Product stage: multiplies element coordinates by the configured strides.
// The tile products are zero-extended to the address width, the others truncated; all are registered.
// Depends on bmp_pkg.
`default_nettype none

module bmp_mul
   import bmp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     elem_valid,
   output logic     elem_ready,
   input  elem_type elem,
   input  logic     next_ready,
   output logic     prod_valid,
   output prod_type prod
);

   logic                       prod_valid_ff, prod_valid_in;
   prod_type                   prod_ff, prod_in;
   logic                       load;
   logic [MAT_W+STRIDE_W-1:0]  src_row_full, src_col_full;
   logic [IDX_W+STRIDE_W-1:0]  block_row_full, block_col_full;
   logic [TIDX_W+STRIDE_W-1:0] tile_row_full, tile_col_full;

   assign elem_ready = !prod_valid_ff || next_ready;
   assign load       = elem_valid && elem_ready;

   assign src_row_full   = elem.mrow * cfg.src_row_stride;
   assign src_col_full   = elem.mcol * cfg.src_col_stride;
   assign block_row_full = elem.row_block * cfg.block_row_stride;
   assign block_col_full = elem.col_block * cfg.block_col_stride;
   assign tile_row_full  = elem.row_in_tile * cfg.tile_row_stride;
   assign tile_col_full  = elem.col_in_tile * cfg.tile_col_stride;

   always_comb begin
      prod_in.src_base       = elem.src_base;
      prod_in.dst_base       = elem.dst_base;
      prod_in.src_row_term   = src_row_full[ADDR_W-1:0];
      prod_in.src_col_term   = src_col_full[ADDR_W-1:0];
      prod_in.block_row_term = block_row_full[ADDR_W-1:0];
      prod_in.block_col_term = block_col_full[ADDR_W-1:0];
      prod_in.tile_row_term  = ADDR_W'(tile_row_full);
      prod_in.tile_col_term  = ADDR_W'(tile_col_full);
      prod_in.pad            = elem.pad;
      prod_in.last           = elem.last;
   end

   always_comb begin
      prod_valid_in = prod_valid_ff;
      if (elem_ready) begin
         prod_valid_in = elem_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod       = prod_ff;

endmodule

`default_nettype wire

>>> design/bmp_sum.sv
// Sum stages: adds bases and stride products into the destination and, for non-pad words,
// the source address. Partial sums are registered once, then the final sum lands in the result register.
// Depends on bmp_pkg.
`default_nettype none

module bmp_sum
   import bmp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              prod_valid,
   output logic              prod_ready,
   input  prod_type          prod,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_src_addr,
   output logic [ADDR_W-1:0] rsp_dst_addr,
   output logic              rsp_pad,
   output logic              rsp_last
);

   logic              part_valid_ff, part_valid_in;
   logic [ADDR_W-1:0] part_src_ff, part_src_in;
   logic [ADDR_W-1:0] part_dst_a_ff, part_dst_a_in;
   logic [ADDR_W-1:0] part_dst_b_ff, part_dst_b_in;
   logic              part_pad_ff, part_last_ff;
   logic              out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0] out_src_ff, out_dst_ff;
   logic              out_pad_ff, out_last_ff;
   logic              out_en, load_part, load_out;

   assign out_en     = !out_valid_ff || rsp_ready;
   assign prod_ready = !part_valid_ff || out_en;
   assign load_part  = prod_valid && prod_ready;
   assign load_out   = part_valid_ff && out_en;

   assign part_src_in   = prod.pad ? '0 :
                          (prod.src_base + prod.src_row_term + prod.src_col_term);
   assign part_dst_a_in = prod.dst_base + prod.block_row_term + prod.block_col_term;
   assign part_dst_b_in = prod.tile_row_term + prod.tile_col_term;

   always_comb begin
      part_valid_in = part_valid_ff;
      if (prod_ready) begin
         part_valid_in = prod_valid;
      end
      out_valid_in = out_valid_ff;
      if (out_en) begin
         out_valid_in = part_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         part_valid_ff <= part_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_part) begin
         part_src_ff   <= part_src_in;
         part_dst_a_ff <= part_dst_a_in;
         part_dst_b_ff <= part_dst_b_in;
         part_pad_ff   <= prod.pad;
         part_last_ff  <= prod.last;
      end
      if (load_out) begin
         out_src_ff  <= part_src_ff;
         out_dst_ff  <= part_dst_a_ff + part_dst_b_ff;
         out_pad_ff  <= part_pad_ff;
         out_last_ff <= part_last_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_src_addr = out_src_ff;
   assign rsp_dst_addr = out_dst_ff;
   assign rsp_pad      = out_pad_ff;
   assign rsp_last     = out_last_ff;

endmodule

`default_nettype wire

>>> design/blocked_matrix_pack_address_gen_core.sv
// A next-element word passes through the counter, product, partial-sum and result
// registers before its result shows; a start word gives no result.
// Throughput: one word per cycle; each stage stalls only when the stage after it is full.
// Reset is synchronous: it clears the counters, the base addresses, the stage valid
// flags and sets the configuration registers to their defaults.
// Top level of the pack address generator; depends on bmp_pkg, bmp_ctr, bmp_mul, bmp_sum.
`default_nettype none

module blocked_matrix_pack_address_gen_core
   import bmp_pkg::*;
#(
   parameter int TILE_ROWS = 8,
   parameter int TILE_COLS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [STRIDE_W-1:0]  csr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cmd,
   input  logic [ADDR_W-1:0]    req_src_base,
   input  logic [ADDR_W-1:0]    req_dst_base,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ADDR_W-1:0]    rsp_src_addr,
   output logic [ADDR_W-1:0]    rsp_dst_addr,
   output logic                 rsp_pad,
   output logic                 rsp_last
);

   cfg_type  cfg_ff, cfg_in;
   logic     elem_valid, elem_ready;
   elem_type elem;
   logic     prod_valid, prod_ready;
   prod_type prod;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ROWS:             cfg_in.rows             = csr_data[DIM_W-1:0];
            CSR_COLS:             cfg_in.cols             = csr_data[DIM_W-1:0];
            CSR_SRC_ROW_STRIDE:   cfg_in.src_row_stride   = csr_data;
            CSR_SRC_COL_STRIDE:   cfg_in.src_col_stride   = csr_data;
            CSR_TILE_ROW_STRIDE:  cfg_in.tile_row_stride  = csr_data;
            CSR_TILE_COL_STRIDE:  cfg_in.tile_col_stride  = csr_data;
            CSR_BLOCK_ROW_STRIDE: cfg_in.block_row_stride = csr_data;
            CSR_BLOCK_COL_STRIDE: cfg_in.block_col_stride = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows             <= DIM_W'(1);
         cfg_ff.cols             <= DIM_W'(1);
         cfg_ff.src_row_stride   <= '0;
         cfg_ff.src_col_stride   <= STRIDE_W'(1);
         cfg_ff.tile_row_stride  <= '0;
         cfg_ff.tile_col_stride  <= STRIDE_W'(1);
         cfg_ff.block_row_stride <= '0;
         cfg_ff.block_col_stride <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bmp_ctr #(
      .TILE_ROWS (TILE_ROWS),
      .TILE_COLS (TILE_COLS)
   ) u_ctr (
      .clock        (clock),
      .reset        (reset),
      .rows         (cfg_ff.rows),
      .cols         (cfg_ff.cols),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_src_base (req_src_base),
      .req_dst_base (req_dst_base),
      .next_ready   (elem_ready),
      .elem_valid   (elem_valid),
      .elem         (elem)
   );

   bmp_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .elem_valid (elem_valid),
      .elem_ready (elem_ready),
      .elem       (elem),
      .next_ready (prod_ready),
      .prod_valid (prod_valid),
      .prod       (prod)
   );

   bmp_sum u_sum (
      .clock        (clock),
      .reset        (reset),
      .prod_valid   (prod_valid),
      .prod_ready   (prod_ready),
      .prod         (prod),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_src_addr (rsp_src_addr),
      .rsp_dst_addr (rsp_dst_addr),
      .rsp_pad      (rsp_pad),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

>>> design/bmp_checker.sv
// Port-level checks for the pack address generator, bound to the top level.
// Depends on bmp_pkg and blocked_matrix_pack_address_gen_core.
`default_nettype none

module bmp_checker
   import bmp_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 csr_valid,
   input wire logic                 csr_ready,
   input wire logic [CSR_IDX_W-1:0] csr_index,
   input wire logic [STRIDE_W-1:0]  csr_data,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 req_cmd,
   input wire logic [ADDR_W-1:0]    req_src_base,
   input wire logic [ADDR_W-1:0]    req_dst_base,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [ADDR_W-1:0]    rsp_src_addr,
   input wire logic [ADDR_W-1:0]    rsp_dst_addr,
   input wire logic                 rsp_pad,
   input wire logic                 rsp_last
);

   // A stalled result word holds its valid and payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_src_addr) &&
      $stable(rsp_dst_addr) && $stable(rsp_pad) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // A pad word never carries a source address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pad |-> rsp_src_addr == '0)
      else $error("pad word with nonzero source address");

   // The pipeline empties on reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // With the result register free or draining, every stage can advance.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request stalled while result side is free");

   // The configuration port never stalls.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind blocked_matrix_pack_address_gen_core bmp_checker u_bmp_checker (
   .clock        (clock),
   .reset        (reset),
   .csr_valid    (csr_valid),
   .csr_ready    (csr_ready),
   .csr_index    (csr_index),
   .csr_data     (csr_data),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_cmd      (req_cmd),
   .req_src_base (req_src_base),
   .req_dst_base (req_dst_base),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_src_addr (rsp_src_addr),
   .rsp_dst_addr (rsp_dst_addr),
   .rsp_pad      (rsp_pad),
   .rsp_last     (rsp_last)
);

`default_nettype wire
